[rtl/uemr_pkg.sv]
// Package for the ultrasonic echo median ranger: widths, constants and shared types.
// It depends on nothing. The front, queue, back and top-level modules import it.
package uemr_pkg;

  // Window length and widths of the counters that follow from it.
  localparam int Samples = 7;
  localparam int CntW    = $clog2(Samples + 1);
  localparam int IdxW    = (Samples > 1) ? $clog2(Samples) : 1;

  // Field widths of the interface.
  localparam int EchoW = 15;
  localparam int DistW = 18;

  // Fixed-point distance scale: distance_q8 = (width * 4496) >> 10.
  localparam int ScaleW    = 13;
  localparam int DistShift = 10;
  localparam int ProdW     = EchoW + ScaleW;
  localparam logic [ScaleW-1:0] DistScale = ScaleW'(4496);

  // Reset value of the timeout register.
  localparam logic [EchoW-1:0] TimeoutReset = EchoW'(30000);

  // Queue depth between the front and the back.
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [EchoW-1:0] width;
    logic             ok;
    logic             last;
  } q_item_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_EMIT
  } back_state_e;

endpackage

[rtl/ultrasonic_echo_median_ranger.sv]
// Ultrasonic echo median ranger, top level: front end, request queue and back end.
// A window's last request passes through the queue and the back end's calc and emit
// states to the result register. One request per cycle while the queue has room; the
// back end's calc and emit states stall the front once the two-entry queue fills.
// Reset (rst_ni, asynchronous, active low) empties the queue, clears the counts and
// sets the timeout register to 30000 us.
module ultrasonic_echo_median_ranger (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [uemr_pkg::EchoW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [uemr_pkg::EchoW-1:0] echo_us_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [uemr_pkg::DistW-1:0] distance_q8_o,
  output logic                       no_echo_o
);
  import uemr_pkg::*;

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  q_item_t push_data;
  q_item_t pop_data;

  // Accepts and classifies requests.
  uemr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .echo_us_i   (echo_us_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decouples the front from the back.
  uemr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  // Sorts, picks the median and delivers the distance.
  uemr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .distance_q8_o (distance_q8_o),
    .no_echo_o     (no_echo_o)
  );

endmodule

[rtl/uemr_front.sv]
// Front end of the ranger: holds the timeout register, accepts and classifies requests.
// It depends on uemr_pkg and pushes classified requests into the queue.
module uemr_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [uemr_pkg::EchoW-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [uemr_pkg::EchoW-1:0] echo_us_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output uemr_pkg::q_item_t       push_data_o
);
  import uemr_pkg::*;

  logic [EchoW-1:0] timeout_q;
  logic [CntW-1:0]  pos_q, pos_d;
  logic             last;
  logic             accept;

  // The timeout register is written whenever the write enable is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // A request is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign last       = (pos_q == CntW'(Samples - 1));

  // Window position counts accepted requests and wraps after the last one.
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = last ? '0 : pos_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Classification: zero or a width above the timeout is no echo.
  assign push_o            = accept;
  assign push_data_o.width = echo_us_i;
  assign push_data_o.ok    = (echo_us_i != '0) && (echo_us_i <= timeout_q);
  assign push_data_o.last  = last;

endmodule

[rtl/uemr_queue.sv]
// Short queue of classified requests between the front and the back of the ranger.
// It depends on uemr_pkg for the item type and depth constants.
module uemr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  uemr_pkg::q_item_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output uemr_pkg::q_item_t pop_data_o,
  output logic              empty_o
);
  import uemr_pkg::*;

  q_item_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Storage for queued requests.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

[rtl/uemr_back.sv]
// Back end of the ranger: sorted width line, median pick, distance scaling and result register.
// It depends on uemr_pkg and takes classified requests from the queue.
module uemr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  uemr_pkg::q_item_t          q_data_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [uemr_pkg::DistW-1:0] distance_q8_o,
  output logic                       no_echo_o
);
  import uemr_pkg::*;

  back_state_e      state_q, state_d;
  logic [EchoW-1:0] store_q [Samples];
  logic [EchoW-1:0] store_d [Samples];
  logic [CntW-1:0]  count_q, count_d;
  logic [Samples-1:0] le;
  logic [CntW-1:0]  ins_pos;
  logic [CntW-1:0]  mid;
  logic             insert;
  logic             calc;
  logic             load_out;
  logic [ProdW-1:0] prod_q;
  logic             none_q;
  logic             out_valid_q;
  logic [DistW-1:0] dist_q;
  logic             no_echo_q;

  // Sequencer: take requests, then compute and deliver the result at window end.
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    calc     = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (q_data_i.last) begin
            state_d = BK_CALC;
          end
        end
      end
      BK_CALC: begin
        calc    = 1'b1;
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Insertion position: the number of held widths not above the new one.
  always_comb begin
    for (int k = 0; k < Samples; k++) begin
      le[k] = (CntW'(k) < count_q) && (store_q[k] <= q_data_i.width);
    end
    ins_pos = CntW'($countones(le));
  end

  assign insert = pop_o && q_data_i.ok && (count_q < CntW'(Samples));

  // The line stays in ascending order: entries at and above the insertion point move up one.
  always_comb begin
    for (int k = 0; k < Samples; k++) begin
      if (CntW'(k) < ins_pos) begin
        store_d[k] = store_q[k];
      end else if (CntW'(k) == ins_pos) begin
        store_d[k] = q_data_i.width;
      end else begin
        store_d[k] = store_q[(k > 0) ? k - 1 : 0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert) begin
      for (int k = 0; k < Samples; k++) begin
        store_q[k] <= store_d[k];
      end
    end
  end

  // Valid width count, cleared once the result has been computed.
  always_comb begin
    count_d = count_q;
    if (calc) begin
      count_d = '0;
    end else if (insert) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Upper median sits at index count/2 of the sorted line; scale it to distance.
  assign mid = count_q >> 1;

  always_ff @(posedge clk_i) begin
    if (calc) begin
      prod_q <= ProdW'(store_q[mid[IdxW-1:0]]) * ProdW'(DistScale);
      none_q <= (count_q == '0);
    end
  end

  // Result register: it holds until the result is taken downstream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      dist_q    <= none_q ? '0 : prod_q[DistShift +: DistW];
      no_echo_q <= none_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_q8_o = dist_q;
  assign no_echo_o     = no_echo_q;

endmodule
